// ===== hw/rtl/istl_pkg.sv =====
// shared types, constants and the cordic angle table
`timescale 1ns / 1ps

package istl_pkg;

    localparam int COORD_W = 40;
    localparam int DP_W    = 64;
    localparam int ANG_W   = 64;
    localparam int CFG_W   = 40;

    localparam logic [2:0] REG_ORIGIN_EAST  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_NORTH = 3'd1;
    localparam logic [2:0] REG_MPP          = 3'd2;
    localparam logic [2:0] REG_TILE_PIX     = 3'd3;
    localparam logic [2:0] REG_RADIUS       = 3'd4;

    localparam logic [63:0] DEG_PER_RAD_Q32 = 64'd246083499208;
    localparam logic [32:0] GAIN_Q32        = 33'd7072781453;

    localparam logic signed [39:0] COORD_MAX = 40'sh7FFFFFFFFF;
    localparam logic signed [39:0] COORD_MIN = -40'sh8000000000;

    // one cordic cell's datapath word
    typedef struct packed {
        logic              vld;
        logic signed [63:0] u1;
        logic signed [63:0] v1;
        logic signed [63:0] z1;
        logic               nz1;
        logic signed [63:0] u2;
        logic signed [63:0] v2;
        logic signed [63:0] z2;
    } cell_t;

    // atan(2^-i) in degrees, Q.32, from the arctan series
    function automatic logic signed [63:0] atan_deg(input int i);
        logic signed [63:0] acc;
        logic [63:0] term;
        int k;
        acc = 64'sd0;
        if (i == 0)
        begin
            acc = 64'sd45 <<< 32;
        end
        else
        begin
            for (k = 0; k < 32; k++)
            begin
                if ((2 * k + 1) * i < 64)
                begin
                    term = (DEG_PER_RAD_Q32 >> ((2 * k + 1) * i)) / 64'(2 * k + 1);
                    if (term != 64'd0)
                    begin
                        acc = (k % 2 == 1) ? acc - $signed(term) : acc + $signed(term);
                    end
                    else
                    begin
                        break;
                    end
                end
            end
        end
        return acc;
    endfunction

endpackage

// ===== hw/rtl/istl_cell.sv =====
// one cordic stage for both vectoring passes
`timescale 1ns / 1ps

module istl_cell #(
    parameter int STAGE = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  istl_pkg::cell_t din,
    output istl_pkg::cell_t dout
);

    localparam logic signed [63:0] ATAN = istl_pkg::atan_deg(STAGE);

    istl_pkg::cell_t dout_reg;
    istl_pkg::cell_t dout_next;

    // rotate both vectors toward the x axis; the first only when nz1 is set
    always_comb
    begin
        dout_next = din;
        if (din.nz1)
        begin
            if (din.v1 >= 0)
            begin
                dout_next.u1 = din.u1 + (din.v1 >>> STAGE);
                dout_next.v1 = din.v1 - (din.u1 >>> STAGE);
                dout_next.z1 = din.z1 + ATAN;
            end
            else
            begin
                dout_next.u1 = din.u1 - (din.v1 >>> STAGE);
                dout_next.v1 = din.v1 + (din.u1 >>> STAGE);
                dout_next.z1 = din.z1 - ATAN;
            end
        end
        if (din.v2 >= 0)
        begin
            dout_next.u2 = din.u2 + (din.v2 >>> STAGE);
            dout_next.v2 = din.v2 - (din.u2 >>> STAGE);
            dout_next.z2 = din.z2 + ATAN;
        end
        else
        begin
            dout_next.u2 = din.u2 - (din.v2 >>> STAGE);
            dout_next.v2 = din.v2 + (din.u2 >>> STAGE);
            dout_next.z2 = din.z2 - ATAN;
        end
    end

    // valid bit and payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dout_reg <= '0;
        end
        else
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule

// ===== hw/rtl/inverse_stereographic_tile_latlon.sv =====
// top level: tile centre, two chained cordic passes, output rounding
`timescale 1ns / 1ps

// channel   ports                              dir  handshake
// input     start, busy, tile_col, tile_row    in   start & !busy
// result    done, lat_deg, lon_deg             out  done strobe, one cycle
// config    cfg_we, cfg_index, cfg_data        in   cfg_we
//
// done is registered through three setup stages, the two cordic chains of
// one cell per stage and the output register.
// busy is always low: one item may enter every cycle.
// reset clears valid bits and loads the register defaults.
// the receiver cannot stall; each done pulse is one result.
module inverse_stereographic_tile_latlon #(
    parameter int CORDIC_STAGES   = 24,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [15:0]         tile_col,
    input  logic [15:0]         tile_row,
    output logic                done,
    output logic signed [23:0]  lat_deg,
    output logic signed [24:0]  lon_deg,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [39:0]         cfg_data
);

    localparam int SH = 32 - ANGLE_FRAC_BITS;

    logic signed [39:0] origin_east_reg;
    logic signed [39:0] origin_north_reg;
    logic [31:0]        mpp_reg;
    logic [16:0]        tile_pix_reg;
    logic [39:0]        radius_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_east_reg  <= '0;
            origin_north_reg <= '0;
            mpp_reg          <= 32'd65536;
            tile_pix_reg     <= 17'd4096;
            radius_reg       <= 40'd444774400;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                istl_pkg::REG_ORIGIN_EAST:  origin_east_reg  <= cfg_data;
                istl_pkg::REG_ORIGIN_NORTH: origin_north_reg <= cfg_data;
                istl_pkg::REG_MPP:          mpp_reg          <= cfg_data[31:0];
                istl_pkg::REG_TILE_PIX:     tile_pix_reg     <= cfg_data[16:0];
                istl_pkg::REG_RADIUS:       radius_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage a: (2*index+1) * tile_pixels
    logic        a_vld_reg;
    logic [33:0] a_pc_reg, a_pr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= start;
        end
    end
    always_ff @(posedge clk)
    begin
        a_pc_reg <= 34'({tile_col, 1'b1}) * 34'(tile_pix_reg);
        a_pr_reg <= 34'({tile_row, 1'b1}) * 34'(tile_pix_reg);
    end

    // stage b: partial products with the scale halves
    logic        b_vld_reg;
    logic [49:0] b_hc_reg, b_lc_reg, b_hr_reg, b_lr_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_vld_reg <= 1'b0;
        end
        else
        begin
            b_vld_reg <= a_vld_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        b_hc_reg <= 50'(a_pc_reg) * 50'(mpp_reg[31:16]);
        b_lc_reg <= 50'(a_pc_reg) * 50'(mpp_reg[15:0]);
        b_hr_reg <= 50'(a_pr_reg) * 50'(mpp_reg[31:16]);
        b_lr_reg <= 50'(a_pr_reg) * 50'(mpp_reg[15:0]);
    end

    // stage c: offsets, saturated coordinates and the gained radius
    function automatic logic signed [39:0] sat_add(input logic signed [39:0] o,
                                                  input logic [49:0] hi,
                                                  input logic [49:0] lo);
        logic signed [59:0] s;
        s = 60'(o) + $signed({3'b0, hi, 7'b0}) + $signed(60'((51'(lo) + 51'd256) >> 9));
        if (s > 60'(istl_pkg::COORD_MAX))
        begin
            return istl_pkg::COORD_MAX;
        end
        if (s < 60'(istl_pkg::COORD_MIN))
        begin
            return istl_pkg::COORD_MIN;
        end
        return s[39:0];
    endfunction

    logic               c_vld_reg;
    logic signed [39:0] c_x_reg, c_y_reg;
    logic [63:0]        c_a_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_vld_reg <= 1'b0;
        end
        else
        begin
            c_vld_reg <= b_vld_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        c_x_reg <= sat_add(origin_east_reg, b_hc_reg, b_lc_reg);
        c_y_reg <= sat_add(origin_north_reg, b_hr_reg, b_lr_reg);
        c_a_reg <= ((64'(radius_reg[39:20]) * 64'(istl_pkg::GAIN_Q32)) << 5)
                 + ((64'(radius_reg[19:0]) * 64'(istl_pkg::GAIN_Q32) + 64'd16384) >> 15);
    end

    // stage d: quadrant fold into the first pass
    istl_pkg::cell_t p1 [0:CORDIC_STAGES];
    always_comb
    begin
        p1[0]     = '0;
        p1[0].vld = c_vld_reg;
        p1[0].nz1 = (c_x_reg != 0) || (c_y_reg != 0);
        p1[0].u1  = 64'(c_y_reg) <<< 16;
        p1[0].v1  = 64'(c_x_reg) <<< 16;
        if (c_y_reg < 0)
        begin
            p1[0].u1 = -(64'(c_y_reg) <<< 16);
            p1[0].v1 = -(64'(c_x_reg) <<< 16);
            p1[0].z1 = (c_x_reg >= 0) ? (64'sd180 <<< 32) : -(64'sd180 <<< 32);
        end
        p1[0].u2 = $signed(c_a_reg);
    end

    // first pass chain: longitude and gained radius
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_p1
        istl_pkg::cell_t d1;
        always_comb
        begin
            d1    = p1[g];
            d1.v2 = 64'sd0;
        end
        istl_cell #(.STAGE(g)) u_cell (.clk(clk), .rst_n(rst_n), .din(d1),
                                       .dout(p1[g + 1]));
    end

    // second pass chain: half colatitude from (2R*K, r*K)
    istl_pkg::cell_t p2 [0:CORDIC_STAGES];
    always_comb
    begin
        p2[0]     = p1[CORDIC_STAGES];
        p2[0].nz1 = 1'b0;
        p2[0].v2  = p1[CORDIC_STAGES].nz1 ? p1[CORDIC_STAGES].u1 : 64'sd0;
        p2[0].z2  = 64'sd0;
        if (!p1[CORDIC_STAGES].nz1)
        begin
            p2[0].z1 = 64'sd0;
        end
    end
    for (genvar g = 0; g < CORDIC_STAGES; g++)
    begin : g_p2
        istl_cell #(.STAGE(g)) u_cell (.clk(clk), .rst_n(rst_n), .din(p2[g]),
                                       .dout(p2[g + 1]));
    end

    // output rounding and clamp
    function automatic logic signed [63:0] round_clamp(input logic signed [63:0] z,
                                                      input logic signed [63:0] lim);
        logic signed [63:0] r;
        r = (z + (64'sd1 <<< (SH - 1))) >>> SH;
        if (r > lim)
        begin
            r = lim;
        end
        if (r < -lim)
        begin
            r = -lim;
        end
        return r;
    endfunction

    // a zero vector into the second pass stays zero and gives no angle
    logic signed [63:0] phi;
    logic signed [63:0] lat_full, lon_full;
    always_comb
    begin
        phi      = (p2[CORDIC_STAGES].u2 != 0) ? p2[CORDIC_STAGES].z2 : 64'sd0;
        lat_full = round_clamp((64'sd90 <<< 32) - (phi <<< 1),
                               64'sd90 <<< ANGLE_FRAC_BITS);
        lon_full = round_clamp(p2[CORDIC_STAGES].z1, 64'sd180 <<< ANGLE_FRAC_BITS);
    end

    logic               done_reg;
    logic signed [23:0] lat_reg;
    logic signed [24:0] lon_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= p2[CORDIC_STAGES].vld;
        end
    end
    always_ff @(posedge clk)
    begin
        lat_reg <= lat_full[23:0];
        lon_reg <= lon_full[24:0];
    end

    assign done    = done_reg;
    assign lat_deg = lat_reg;
    assign lon_deg = lon_reg;

endmodule

// ===== dv/inverse_stereographic_tile_latlon_tb.sv =====
// testbench for the tile centre to latitude and longitude projector
`timescale 1ns / 1ps

module inverse_stereographic_tile_latlon_tb;

    localparam int STAGES    = 24;
    localparam int FRAC      = 16;
    localparam int LATENCY   = 2 * STAGES + 3;
    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic signed [23:0] lat;
        logic signed [24:0] lon;
    } latlon_t;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [15:0]        tile_col;
    logic [15:0]        tile_row;
    logic               done;
    logic signed [23:0] lat_deg;
    logic signed [24:0] lon_deg;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [39:0]        cfg_data;

    // shadow copy of the block registers
    logic signed [39:0] sh_east;
    logic signed [39:0] sh_north;
    logic [31:0]        sh_mpp;
    logic [16:0]        sh_tpix;
    logic [39:0]        sh_radius;

    latlon_t            pending_angles[$];
    int                 mismatches;
    int                 cycles;
    int                 send_idle_pct;
    logic signed [63:0] atan_tab[STAGES];

    inverse_stereographic_tile_latlon #(
        .CORDIC_STAGES(STAGES),
        .ANGLE_FRAC_BITS(FRAC)
    ) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .tile_col(tile_col), .tile_row(tile_row),
        .done(done), .lat_deg(lat_deg), .lon_deg(lon_deg),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #2 clk = ~clk;

    // arctan series in degrees, q.32
    function automatic logic signed [63:0] arctan_step(int i);
        logic signed [63:0] acc;
        logic [63:0] term;
        int k;
        acc = 0;
        if (i == 0)
            return 64'sd45 <<< 32;
        for (k = 0; (2 * k + 1) * i < 64; k++)
        begin
            term = (64'd246083499208 >> ((2 * k + 1) * i)) / 64'(2 * k + 1);
            if (term == 0)
                break;
            acc = (k % 2 == 1) ? acc - $signed(term) : acc + $signed(term);
        end
        return acc;
    endfunction

    // vectoring rotation, returns accumulated angle
    function automatic logic signed [63:0] vector_angle(inout logic signed [63:0] u,
                                                       inout logic signed [63:0] v);
        logic signed [63:0] z;
        logic signed [63:0] du;
        logic signed [63:0] dv;
        z = 0;
        for (int i = 0; i < STAGES; i++)
        begin
            du = v >>> i;
            dv = u >>> i;
            if (v >= 0)
            begin
                u = u + du; v = v - dv; z = z + atan_tab[i];
            end
            else
            begin
                u = u - du; v = v + dv; z = z - atan_tab[i];
            end
        end
        return z;
    endfunction

    function automatic logic signed [63:0] centre_offset(logic [15:0] idx);
        logic [63:0] p2;
        logic [63:0] hi;
        logic [63:0] lo;
        p2 = (64'(idx) * 2 + 1) * 64'(sh_tpix);
        hi = p2 * 64'(sh_mpp[31:16]);
        lo = p2 * 64'(sh_mpp[15:0]);
        return $signed((hi << 7) + ((lo + 256) >> 9));
    endfunction

    function automatic logic signed [63:0] sat40(logic signed [63:0] v);
        if (v > 64'sd549755813887)
            return 64'sd549755813887;
        if (v < -64'sd549755813888)
            return -64'sd549755813888;
        return v;
    endfunction

    function automatic logic signed [63:0] round_clamp(logic signed [63:0] z, int lim_deg);
        logic signed [63:0] r;
        logic signed [63:0] lim;
        lim = 64'(lim_deg) <<< FRAC;
        r = (z + (64'sd1 <<< (31 - FRAC))) >>> (32 - FRAC);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r;
    endfunction

    function automatic latlon_t project_tile(logic [15:0] col, logic [15:0] row);
        logic signed [63:0] x, y, u, v, a, b, base, lon_z, phi_z;
        logic [63:0] rh, rl;
        latlon_t res;
        x = sat40(64'(sh_east) + centre_offset(col));
        y = sat40(64'(sh_north) + centre_offset(row));
        lon_z = 0; phi_z = 0; b = 0;
        if (x != 0 || y != 0)
        begin
            base = 0;
            u = y * 65536;
            v = x * 65536;
            if (u < 0)
            begin
                base = (x >= 0) ? (64'sd180 <<< 32) : -(64'sd180 <<< 32);
                u = -u;
                v = -v;
            end
            lon_z = base + vector_angle(u, v);
            b = u;
        end
        rh = 64'(sh_radius) >> 20;
        rl = 64'(sh_radius[19:0]);
        a = $signed(((rh * 64'd7072781453) << 5) + ((rl * 64'd7072781453 + 16384) >> 15));
        if (a != 0 || b != 0)
        begin
            u = a;
            v = b;
            phi_z = vector_angle(u, v);
        end
        res.lat = 24'(round_clamp((64'sd90 <<< 32) - 2 * phi_z, 90));
        res.lon = 25'(round_clamp(lon_z, 180));
        return res;
    endfunction

    // result check on each done strobe
    always @(posedge clk)
    begin
        latlon_t want;
        if (rst_n && done)
        begin
            if (pending_angles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat lat=%0d lon=%0d", lat_deg, lon_deg);
            end
            else
            begin
                want = pending_angles.pop_front();
                if (want.lat !== lat_deg || want.lon !== lon_deg)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch lat exp %0d got %0d, lon exp %0d got %0d",
                                 want.lat, lat_deg, want.lon, lon_deg);
                end
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLES)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [39:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        case (idx)
            istl_pkg::REG_ORIGIN_EAST:  sh_east = val;
            istl_pkg::REG_ORIGIN_NORTH: sh_north = val;
            istl_pkg::REG_MPP:          sh_mpp = val[31:0];
            istl_pkg::REG_TILE_PIX:     sh_tpix = val[16:0];
            istl_pkg::REG_RADIUS:       sh_radius = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // send one tile beat, with optional idle cycles before it
    task automatic send_tile(logic [15:0] col, logic [15:0] row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start = 1'b0;
            @(negedge clk);
        end
        start = 1'b1;
        tile_col = col;
        tile_row = row;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_angles.push_back(project_tile(col, row));
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic drain;
        while (pending_angles.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic set_config(logic [39:0] e, logic [39:0] n, logic [31:0] m,
                              logic [16:0] t, logic [39:0] r);
        drain();
        write_reg(istl_pkg::REG_ORIGIN_EAST, e);
        write_reg(istl_pkg::REG_ORIGIN_NORTH, n);
        write_reg(istl_pkg::REG_MPP, {8'd0, m});
        write_reg(istl_pkg::REG_TILE_PIX, {23'd0, t});
        write_reg(istl_pkg::REG_RADIUS, r);
    endtask

    // corners, origin centre, negative y and axis cases
    task automatic test_directed;
        send_tile(16'd0, 16'd0);
        send_tile(16'hFFFF, 16'hFFFF);
        send_tile(16'hFFFF, 16'd0);
        send_tile(16'd0, 16'hFFFF);
        send_tile(16'h5555, 16'hAAAA);
        // centre lands on the origin
        set_config(-40'sd128, -40'sd128, 32'd65536, 17'd1, 40'd444774400);
        send_tile(16'd0, 16'd0);
        send_tile(16'd1, 16'd0);
        send_tile(16'd0, 16'd1);
        // negative y, both signs of x
        set_config(40'sd0, -40'sd100000000, 32'd65536, 17'd1, 40'd444774400);
        send_tile(16'd0, 16'd0);
        set_config(-40'sd100000000, -40'sd100000000, 32'd65536, 17'd1, 40'd444774400);
        send_tile(16'd0, 16'd0);
        send_tile(16'd3, 16'd2);
        // zero radius, zero scale, zero tile size, saturation
        set_config(40'sd0, 40'sd0, 32'd65536, 17'd4096, 40'd0);
        send_tile(16'd7, 16'd9);
        send_tile(16'd0, 16'd0);
        set_config(40'sd1000, -40'sd1000, 32'd0, 17'd0, 40'd256);
        send_tile(16'd12, 16'd34);
        set_config(40'sh7FFFFFFFFF, 40'sh8000000000, 32'hFFFFFFFF, 17'd65536,
                   40'hFFFFFFFFFF);
        send_tile(16'hFFFF, 16'hFFFF);
        send_tile(16'd0, 16'd0);
        set_config(40'sh8000000000, 40'sh7FFFFFFFFF, 32'd1, 17'd1, 40'd256);
        send_tile(16'hFFFF, 16'h0001);
        // out-of-range register index is ignored
        drain();
        write_reg(3'd7, 40'hFFFFFFFFFF);
        write_reg(3'd5, 40'h123456789A);
        send_tile(16'd100, 16'd200);
    endtask

    // random configurations and tiles
    task automatic test_random(int beats);
        logic [39:0] e, n, r;
        for (int i = 0; i < beats; i++)
        begin
            if (i % 150 == 0)
            begin
                e = 40'({$urandom, $urandom});
                n = 40'({$urandom, $urandom});
                if ($urandom_range(1))
                begin
                    e = $signed(e) >>> $urandom_range(36, 8);
                    n = $signed(n) >>> $urandom_range(36, 8);
                end
                r = 40'({$urandom, $urandom});
                if ($urandom_range(1))
                    r = r >> $urandom_range(20, 4);
                set_config(e, n, $urandom_range(1) ? $urandom : $urandom_range(1 << 20, 1),
                           17'($urandom_range(65536, 1)), r);
            end
            if ($urandom_range(3) == 0)
                send_tile(16'($urandom), 16'($urandom));
            else
                send_tile(16'($urandom_range(255)), 16'($urandom_range(255)));
        end
    endtask

    initial
    begin
        for (int i = 0; i < STAGES; i++)
            atan_tab[i] = arctan_step(i);
        mismatches = 0;
        cycles = 0;
        send_idle_pct = 20;
        start = 1'b0;
        tile_col = '0;
        tile_row = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sh_east = 0;
        sh_north = 0;
        sh_mpp = 32'd65536;
        sh_tpix = 17'd4096;
        sh_radius = 40'd444774400;
        rst_n = 1'b0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        send_idle_pct = 20;
        test_random(450);
        send_idle_pct = 47;
        test_random(450);
        send_idle_pct = 0;
        test_random(450);
        drain();

        if (mismatches == 0 && pending_angles.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/istl_pkg.sv
hw/rtl/istl_cell.sv
hw/rtl/inverse_stereographic_tile_latlon.sv
dv/inverse_stereographic_tile_latlon_tb.sv
